/* rtl/bemf_pkg.sv */
// Shared widths, codes and reset constants for the back-EMF speed regulator.
// Used by bemf_div and back_emf_speed_regulator; depends on nothing.
package bemf_pkg;

  // Field widths
  localparam int unsigned ADC_BITS   = 10;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned SUM_W      = ADC_BITS + COUNT_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(SUM_W + 1);
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;

  // Phase codes
  localparam logic [1:0] PH_RUN     = 2'd0;
  localparam logic [1:0] PH_DRAIN   = 2'd1;
  localparam logic [1:0] PH_MEASURE = 2'd2;

  // Action codes
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_STOP = 2'd1;
  localparam logic [1:0] ACT_EXEC = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE  = 3'd4;

  // Reset values of the period registers
  localparam logic [TIME_W-1:0] RUN_RESET     = 32'd100000;
  localparam logic [TIME_W-1:0] DRAIN_RESET   = 32'd2000;
  localparam logic [TIME_W-1:0] MEASURE_RESET = 32'd2000;

  // Speed clamp ceiling
  localparam int unsigned SPEED_MAX = 255;

endpackage

/* rtl/bemf_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, SUM_W quotient bits a run.
// Depends on bemf_pkg for the dividend, divisor and counter widths.
module bemf_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [bemf_pkg::SUM_W-1:0]         dividend_i,
  input  logic [bemf_pkg::COUNT_BITS-1:0]    divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [bemf_pkg::SUM_W-1:0]         quotient_o
);

  logic                               busy_q, busy_d;
  logic [bemf_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [bemf_pkg::SUM_W-1:0]         quo_q, quo_d;
  logic [bemf_pkg::COUNT_BITS-1:0]    rem_q, rem_d;
  logic [bemf_pkg::COUNT_BITS-1:0]    div_q, div_d;
  logic [bemf_pkg::COUNT_BITS:0]      shifted;
  logic [bemf_pkg::COUNT_BITS:0]      trial;
  logic                               last;

  // Bring down the next dividend bit and try the subtract
  assign shifted = {rem_q, quo_q[bemf_pkg::SUM_W-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign last    = (cnt_q == bemf_pkg::DIV_CNT_W'(bemf_pkg::SUM_W - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // Restore when the trial goes negative, else keep the difference
      if (shifted >= {1'b0, div_q}) begin
        rem_d = trial[bemf_pkg::COUNT_BITS-1:0];
        quo_d = {quo_q[bemf_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[bemf_pkg::COUNT_BITS-1:0];
        quo_d = {quo_q[bemf_pkg::SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = busy_q && last;
  assign quotient_o = quo_q;

endmodule

/* rtl/back_emf_speed_regulator.sv */
// Top level of the two-motor back-EMF speed regulator: sequencer, state,
// configuration registers and output register. Depends on bemf_pkg, bemf_div.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one service tick per beat:
//   timestamp, moving flag, one ADC sample per motor and the present speeds.
//   Output channel (out_valid_o/out_ready_i) returns exactly one beat per
//   tick: action, held left/right speed commands and the phase after the tick.
//   Configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
//   writes the targets and periods; it is always ready. It is to be written
//   only while the block is idle, which the user must keep to; the block
//   itself does not enforce it. Indexes beyond the register list are ignored.
//   A tick that ends a measure window runs both channel averages through
//   bit-serial dividers, one quotient bit per cycle, before its result is
//   loaded. The next tick is accepted no earlier than the cycle after the
//   result is loaded. The dividend width (ADC_BITS + COUNT_BITS) sets the
//   divide length. Reset clears the sequencer, regulator state and targets
//   and restores the period registers to their defaults. When the receiver
//   stalls, the finished beat holds in the output register; one further
//   tick is accepted and computed, then waits.
module back_emf_speed_regulator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bemf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bemf_pkg::TIME_W-1:0]       cfg_data_i,
  // Tick input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bemf_pkg::TIME_W-1:0]       time_us_i,
  input  logic                              moving_i,
  input  logic [bemf_pkg::ADC_BITS-1:0]     sample_a_i,
  input  logic [bemf_pkg::ADC_BITS-1:0]     sample_b_i,
  input  logic [bemf_pkg::SPEED_W-1:0]      current_left_speed_i,
  input  logic [bemf_pkg::SPEED_W-1:0]      current_right_speed_i,
  // Result output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        action_o,
  output logic [bemf_pkg::SPEED_W-1:0]      left_speed_o,
  output logic [bemf_pkg::SPEED_W-1:0]      right_speed_o,
  output logic [1:0]                        phase_o
);

  localparam int unsigned DIFF_W = bemf_pkg::SUM_W + 3;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_ADJ  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // Configuration registers
  logic [bemf_pkg::ADC_BITS-1:0]   target_a_q, target_b_q;
  logic [bemf_pkg::TIME_W-1:0]     run_q, drain_q, measure_q;

  // Sequencer and regulator state
  logic [2:0]                      state_q, state_d;
  logic [1:0]                      phase_q, phase_d;
  logic [1:0]                      action_q, action_d;
  logic [bemf_pkg::TIME_W-1:0]     last_time_q, last_time_d;
  logic [bemf_pkg::SUM_W-1:0]      sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [bemf_pkg::COUNT_BITS-1:0] count_q, count_d;
  logic [bemf_pkg::SPEED_W-1:0]    held_l_q, held_l_d, held_r_q, held_r_d;

  // Captured tick
  logic [bemf_pkg::TIME_W-1:0]     time_q;
  logic                            moving_q;
  logic [bemf_pkg::ADC_BITS-1:0]   sa_q, sb_q;
  logic [bemf_pkg::SPEED_W-1:0]    cl_q, cr_q;

  // Output register
  logic                            out_valid_q, out_valid_d;
  logic [1:0]                      out_action_q, out_phase_q;
  logic [bemf_pkg::SPEED_W-1:0]    out_left_q, out_right_q;
  logic                            out_load;

  // Evaluation and divider signals
  logic [bemf_pkg::TIME_W-1:0]     elapsed;
  logic                            div_start;
  logic                            div_a_busy, div_b_busy, div_a_done, div_b_done;
  logic [bemf_pkg::SUM_W-1:0]      quo_a, quo_b;
  logic [bemf_pkg::SPEED_W-1:0]    new_l, new_r;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign elapsed     = time_q - last_time_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_a_q <= '0;
      target_b_q <= '0;
      run_q      <= bemf_pkg::RUN_RESET;
      drain_q    <= bemf_pkg::DRAIN_RESET;
      measure_q  <= bemf_pkg::MEASURE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bemf_pkg::REG_TARGET_A: target_a_q <= cfg_data_i[bemf_pkg::ADC_BITS-1:0];
        bemf_pkg::REG_TARGET_B: target_b_q <= cfg_data_i[bemf_pkg::ADC_BITS-1:0];
        bemf_pkg::REG_RUN:      run_q      <= cfg_data_i;
        bemf_pkg::REG_DRAIN:    drain_q    <= cfg_data_i;
        bemf_pkg::REG_MEASURE:  measure_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Average, half the signed error, clamp: one channel
  function automatic logic [bemf_pkg::SPEED_W-1:0] adjust(
    input logic [bemf_pkg::SUM_W-1:0]    quo,
    input logic                          count_zero,
    input logic [bemf_pkg::ADC_BITS-1:0] target,
    input logic [bemf_pkg::SPEED_W-1:0]  held
  );
    logic [bemf_pkg::SUM_W-1:0] avg;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   half;
    logic signed [DIFF_W-1:0]   v;
    avg  = count_zero ? '0 : quo;
    diff = $signed(DIFF_W'(target)) - $signed({3'b000, avg});
    // Truncate toward zero: bias negatives by one before the shift
    half = (diff + $signed(DIFF_W'(diff[DIFF_W-1]))) >>> 1;
    v    = $signed(DIFF_W'(held)) + half;
    if (v < 0) begin
      adjust = '0;
    end else if (v > $signed(DIFF_W'(bemf_pkg::SPEED_MAX))) begin
      adjust = bemf_pkg::SPEED_W'(bemf_pkg::SPEED_MAX);
    end else begin
      adjust = v[bemf_pkg::SPEED_W-1:0];
    end
  endfunction

  assign new_l = adjust(quo_a, count_q == '0, target_a_q, held_l_q);
  assign new_r = adjust(quo_b, count_q == '0, target_b_q, held_r_q);

  // Sequence one tick
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    action_d    = action_q;
    last_time_d = last_time_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    count_d     = count_q;
    held_l_d    = held_l_q;
    held_r_d    = held_r_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        action_d = bemf_pkg::ACT_NONE;
        state_d  = ST_OUT;
        if (target_a_q != '0 || target_b_q != '0) begin
          priority if (phase_q == bemf_pkg::PH_DRAIN) begin
            if (elapsed > drain_q) begin
              phase_d     = bemf_pkg::PH_MEASURE;
              sum_a_d     = '0;
              sum_b_d     = '0;
              count_d     = '0;
              last_time_d = time_q;
            end
          end else if (phase_q == bemf_pkg::PH_MEASURE) begin
            // Accumulate unless the count has saturated
            if (count_q != '1) begin
              sum_a_d = sum_a_q + bemf_pkg::SUM_W'(sa_q);
              sum_b_d = sum_b_q + bemf_pkg::SUM_W'(sb_q);
              count_d = count_q + 1'b1;
            end
            if (elapsed > measure_q) begin
              div_start   = 1'b1;
              action_d    = bemf_pkg::ACT_EXEC;
              phase_d     = bemf_pkg::PH_RUN;
              last_time_d = time_q;
              state_d     = ST_DIV;
            end
          end else begin
            phase_d = bemf_pkg::PH_RUN;
            if (moving_q && elapsed > run_q) begin
              held_l_d    = cl_q;
              held_r_d    = cr_q;
              action_d    = bemf_pkg::ACT_STOP;
              phase_d     = bemf_pkg::PH_DRAIN;
              last_time_d = time_q;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_a_done) begin
          state_d = ST_ADJ;
        end
      end
      ST_ADJ: begin
        held_l_d = new_l;
        held_r_d = new_r;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        // Load the result once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Control and regulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= bemf_pkg::PH_RUN;
      action_q    <= bemf_pkg::ACT_NONE;
      last_time_q <= '0;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      count_q     <= '0;
      held_l_q    <= '0;
      held_r_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      action_q    <= action_d;
      last_time_q <= last_time_d;
      sum_a_q     <= sum_a_d;
      sum_b_q     <= sum_b_d;
      count_q     <= count_d;
      held_l_q    <= held_l_d;
      held_r_q    <= held_r_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the tick beat
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      time_q   <= time_us_i;
      moving_q <= moving_i;
      sa_q     <= sample_a_i;
      sb_q     <= sample_b_i;
      cl_q     <= current_left_speed_i;
      cr_q     <= current_right_speed_i;
    end
  end

  // Hold the result beat
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_action_q <= action_q;
      out_phase_q  <= phase_q;
      out_left_q   <= held_l_q;
      out_right_q  <= held_r_q;
    end
  end

  // Channel averages: two serial dividers run in lock step
  bemf_div u_div_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_a_d),
    .divisor_i  (count_d),
    .busy_o     (div_a_busy),
    .done_o     (div_a_done),
    .quotient_o (quo_a)
  );

  bemf_div u_div_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_b_d),
    .divisor_i  (count_d),
    .busy_o     (div_b_busy),
    .done_o     (div_b_done),
    .quotient_o (quo_b)
  );

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_action_q;
  assign left_speed_o  = out_left_q;
  assign right_speed_o = out_right_q;
  assign phase_o       = out_phase_q;

  // Phase register never takes the unused code
  a_phase_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("phase register holds unused code");

  // Both dividers finish together
  a_div_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_a_busy == div_b_busy) && (div_a_done == div_b_done))
    else $error("channel dividers out of step");

  // No tick is taken while a divide is running
  a_idle_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_a_busy)
    else $error("input ready during divide");

  // An execute beat always returns to running, a stop beat to draining
  a_action_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((action_o != bemf_pkg::ACT_EXEC || phase_o == bemf_pkg::PH_RUN) &&
                     (action_o != bemf_pkg::ACT_STOP || phase_o == bemf_pkg::PH_DRAIN)))
    else $error("result action and phase disagree");

endmodule
